// ===== src/assert_macros.svh =====
// Assertion macros used by the port-level checker.
// No dependencies; take in with an include of the bare file name.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked assertion, switched off while reset is asserted.
`define FPRM_ASSERT_RST(lbl, clk_s, rst_s, prop, msg) \
    lbl: assert property (@(posedge clk_s) disable iff (!rst_s) prop) \
        else $error(msg);

// Clocked assertion that also holds through reset.
`define FPRM_ASSERT_CLK(lbl, clk_s, prop, msg) \
    lbl: assert property (@(posedge clk_s) prop) else $error(msg);

`endif

// ===== src/fprm_pkg.sv =====
// Frame pacer / rate meter package: item types, field widths, codes and reset values.
// No dependencies.
`timescale 1ns / 1ps

package fprm_pkg;

    localparam int TICKS_W    = 48;
    localparam int RATE_W     = 24;
    localparam int PERIOD_W   = 32;
    localparam int TRATE_W    = 30;
    localparam int RATE_FRAC  = 8;
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 32;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_FRAME_PERIOD = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_TICK_RATE    = 1'b1;

    // item kinds
    localparam logic KIND_BEGIN = 1'b0;
    localparam logic KIND_POLL  = 1'b1;

    localparam logic [PERIOD_W-1:0] FRAME_PERIOD_RST = 32'd16667;
    localparam logic [TRATE_W-1:0]  TICK_RATE_RST    = 30'd1000000;

    typedef struct packed {
        logic               kind;
        logic [TICKS_W-1:0] now_ticks;
    } in_item_t;

    typedef struct packed {
        logic               frame_ready;
        logic [RATE_W-1:0]  frame_rate;
        logic [RATE_W-1:0]  average_rate;
        logic [TICKS_W-1:0] elapsed_ticks;
    } out_item_t;

endpackage

// ===== src/frame_pacer_rate_meter_unit.sv =====
// Frame pacer with moving-average rate meter, top level.
// Depends on fprm_pkg.
`timescale 1ns / 1ps

// Takes one item at a time. A begin item or a poll that releases no frame
// passes through S_CHECK and then S_FIN, where its result is loaded into the
// output register. A releasing poll runs two bit-serial restoring divisions
// on one shared divider, first the frame rate (tick_rate*256 + interval/2) /
// interval, then the mean (sum + count/2) / count, each on a NUM_W-bit
// numerator with NUM_W = max(TIME_BITS, 38, 24 + clog2(HISTORY_DEPTH+1)) + 1.
// The input stalls while an item is in flight; a finished result sits in the
// output register and a new item is taken while it waits. The rate history
// is a HISTORY_DEPTH-entry memory with a running sum; it needs no clearing
// after reset.
module frame_pacer_rate_meter_unit #(
    parameter int HISTORY_DEPTH = 60,
    parameter int TIME_BITS     = 48
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                in_valid,
    output logic                                in_stall,
    input  fprm_pkg::in_item_t                  in_data,
    output logic                                out_valid,
    input  logic                                out_stall,
    output fprm_pkg::out_item_t                 out_data,
    input  logic                                cfg_we,
    input  logic [fprm_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [fprm_pkg::CFG_DATA_W-1:0]     cfg_data
);
    import fprm_pkg::*;

    localparam int RATE_NUM_W = TRATE_W + RATE_FRAC;
    localparam int CNT_W      = $clog2(HISTORY_DEPTH + 1);
    localparam int SUM_W      = RATE_W + CNT_W;
    localparam int SLOT_W     = (HISTORY_DEPTH > 1) ? $clog2(HISTORY_DEPTH) : 1;
    localparam int NUM_A      = (TIME_BITS > RATE_NUM_W) ? TIME_BITS : RATE_NUM_W;
    localparam int NUM_W      = ((NUM_A > SUM_W) ? NUM_A : SUM_W) + 1;
    localparam int DCNT_W     = $clog2(NUM_W);
    localparam int REM_W      = TIME_BITS + 1;
    localparam int CMP_W      = ((TIME_BITS > PERIOD_W) ? TIME_BITS : PERIOD_W) + 1;
    localparam int EXT_W      = (TIME_BITS > TICKS_W) ? TIME_BITS : TICKS_W;

    typedef enum logic [2:0] {
        S_IDLE,
        S_CHECK,
        S_RLOAD,
        S_RDIV,
        S_UPD,
        S_MLOAD,
        S_MDIV,
        S_FIN
    } state_t;

    state_t                 state_reg;
    logic                   mset_reg;

    logic [PERIOD_W-1:0]    frame_period_reg;
    logic [TRATE_W-1:0]     tick_rate_reg;

    logic                   kind_reg;
    logic [TIME_BITS-1:0]   now_reg;
    logic [TIME_BITS-1:0]   start_reg;
    logic [TIME_BITS-1:0]   last_reg;
    logic [TIME_BITS-1:0]   interval_reg;
    logic [TIME_BITS-1:0]   elapsed_reg;
    logic                   ready_reg;
    logic [RATE_W-1:0]      cur_rate_reg;
    logic [RATE_W-1:0]      mean_reg;
    logic [SLOT_W-1:0]      slot_reg;
    logic [CNT_W-1:0]       fill_reg;
    logic [SUM_W-1:0]       sum_reg;

    // shared serial divider
    logic [NUM_W-1:0]       div_num_reg;
    logic [TIME_BITS-1:0]   div_den_reg;
    logic [REM_W-1:0]       div_rem_reg;
    logic [RATE_W-1:0]      div_q_reg;
    logic                   div_ovf_reg;
    logic [DCNT_W-1:0]      div_cnt_reg;

    logic                   out_valid_reg;
    out_item_t              out_data_reg;

    logic [RATE_W-1:0]      hist_mem [HISTORY_DEPTH];
    logic [RATE_W-1:0]      old_rate_reg;

    logic [EXT_W-1:0]       now_ext;
    logic [EXT_W-1:0]       elapsed_ext;
    logic [CMP_W-1:0]       threshold;
    logic                   release_frame;
    logic [REM_W-1:0]       div_trial;
    logic                   div_qbit;
    logic [REM_W-1:0]       div_rem_next;
    logic [RATE_W-1:0]      rate_sat;
    logic                   hist_full;
    logic [SUM_W-1:0]       sum_next;
    logic                   out_load;

    assign now_ext       = EXT_W'(in_data.now_ticks);
    assign elapsed_ext   = EXT_W'(elapsed_reg);
    assign threshold     = CMP_W'(last_reg) + CMP_W'(frame_period_reg);
    assign release_frame = (CMP_W'(now_reg) >= threshold);

    // one restoring step a cycle
    assign div_trial    = {div_rem_reg[REM_W-2:0], div_num_reg[NUM_W-1]};
    assign div_qbit     = (div_trial >= {1'b0, div_den_reg});
    assign div_rem_next = div_qbit ? (div_trial - {1'b0, div_den_reg}) : div_trial;
    assign rate_sat     = div_ovf_reg ? {RATE_W{1'b1}} : div_q_reg;

    assign hist_full = (fill_reg == CNT_W'(HISTORY_DEPTH));
    assign sum_next  = sum_reg - (hist_full ? SUM_W'(old_rate_reg) : {SUM_W{1'b0}})
                       + SUM_W'(rate_sat);

    // result goes into the output register in S_FIN, once any pending mean is taken and the slot is free
    assign out_load  = (state_reg == S_FIN) && !mset_reg && (!out_valid_reg || !out_stall);

    assign in_stall  = (state_reg != S_IDLE);
    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

    always_ff @(posedge clk)
    begin
        if (state_reg == S_UPD)
        begin
            hist_mem[slot_reg] <= rate_sat;
        end
        old_rate_reg <= hist_mem[slot_reg];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= S_IDLE;
            mset_reg         <= 1'b0;
            frame_period_reg <= FRAME_PERIOD_RST;
            tick_rate_reg    <= TICK_RATE_RST;
            start_reg        <= '0;
            last_reg         <= '0;
            cur_rate_reg     <= '0;
            mean_reg         <= '0;
            slot_reg         <= '0;
            fill_reg         <= '0;
            sum_reg          <= '0;
            out_valid_reg    <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                case (cfg_index)
                    CFG_FRAME_PERIOD: frame_period_reg <= cfg_data[PERIOD_W-1:0];
                    CFG_TICK_RATE:    tick_rate_reg    <= cfg_data[TRATE_W-1:0];
                    default:          ;
                endcase
            end

            if (out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_valid_reg && !out_stall)
            begin
                out_valid_reg <= 1'b0;
            end

            case (state_reg)
                S_IDLE:
                begin
                    if (in_valid)
                    begin
                        kind_reg  <= in_data.kind;
                        now_reg   <= now_ext[TIME_BITS-1:0];
                        state_reg <= S_CHECK;
                    end
                end
                S_CHECK:
                begin
                    if (kind_reg == KIND_BEGIN)
                    begin
                        ready_reg    <= 1'b0;
                        start_reg    <= now_reg;
                        last_reg     <= now_reg;
                        cur_rate_reg <= '0;
                        mean_reg     <= '0;
                        elapsed_reg  <= '0;
                        state_reg    <= S_FIN;
                    end
                    else
                    begin
                        elapsed_reg <= now_reg - start_reg;
                        if (release_frame)
                        begin
                            interval_reg <= now_reg - last_reg;
                            last_reg     <= now_reg;
                            ready_reg    <= 1'b1;
                            state_reg    <= S_RLOAD;
                        end
                        else
                        begin
                            ready_reg <= 1'b0;
                            state_reg <= S_FIN;
                        end
                    end
                end
                S_RLOAD:
                begin
                    div_num_reg <= NUM_W'({tick_rate_reg, {RATE_FRAC{1'b0}}})
                                   + NUM_W'(interval_reg >> 1);
                    div_den_reg <= interval_reg;
                    div_rem_reg <= '0;
                    div_q_reg   <= '0;
                    div_ovf_reg <= 1'b0;
                    div_cnt_reg <= DCNT_W'(NUM_W - 1);
                    state_reg   <= S_RDIV;
                end
                S_RDIV, S_MDIV:
                begin
                    div_num_reg <= div_num_reg << 1;
                    div_rem_reg <= div_rem_next;
                    div_q_reg   <= {div_q_reg[RATE_W-2:0], div_qbit};
                    div_ovf_reg <= div_ovf_reg | div_q_reg[RATE_W-1];
                    div_cnt_reg <= div_cnt_reg - DCNT_W'(1);
                    if (div_cnt_reg == '0)
                    begin
                        if (state_reg == S_RDIV)
                        begin
                            state_reg <= S_UPD;
                        end
                        else
                        begin
                            mset_reg  <= 1'b1;
                            state_reg <= S_FIN;
                        end
                    end
                end
                S_UPD:
                begin
                    cur_rate_reg <= rate_sat;
                    sum_reg      <= sum_next;
                    if (!hist_full)
                    begin
                        fill_reg <= fill_reg + CNT_W'(1);
                    end
                    if (slot_reg == SLOT_W'(HISTORY_DEPTH - 1))
                    begin
                        slot_reg <= '0;
                    end
                    else
                    begin
                        slot_reg <= slot_reg + SLOT_W'(1);
                    end
                    state_reg <= S_MLOAD;
                end
                S_MLOAD:
                begin
                    div_num_reg <= NUM_W'(sum_reg) + NUM_W'(fill_reg >> 1);
                    div_den_reg <= TIME_BITS'(fill_reg);
                    div_rem_reg <= '0;
                    div_q_reg   <= '0;
                    div_ovf_reg <= 1'b0;
                    div_cnt_reg <= DCNT_W'(NUM_W - 1);
                    state_reg   <= S_MDIV;
                end
                S_FIN:
                begin
                    // the mean quotient is taken once, on the first cycle here
                    if (mset_reg)
                    begin
                        mean_reg <= rate_sat;
                        mset_reg <= 1'b0;
                    end
                    else if (out_load)
                    begin
                        out_data_reg.frame_ready   <= ready_reg;
                        out_data_reg.frame_rate    <= cur_rate_reg;
                        out_data_reg.average_rate  <= mean_reg;
                        out_data_reg.elapsed_ticks <= elapsed_ext[TICKS_W-1:0];
                        state_reg                  <= S_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

endmodule

// ===== src/fprm_checker.sv =====
// Port-level checker for the frame pacer / rate meter, with its bind.
// Depends on fprm_pkg, assert_macros.svh and frame_pacer_rate_meter_unit.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module fprm_port_checks (
    input logic                clk,
    input logic                rst_n,
    input logic                in_valid,
    input logic                in_stall,
    input logic                out_valid,
    input logic                out_stall,
    input fprm_pkg::out_item_t out_data
);
    import fprm_pkg::*;

    // one item in flight: the input is busy straight after an item is taken
    `FPRM_ASSERT_RST(a_busy_after_accept, clk, rst_n, $past(rst_n) && $past(in_valid && !in_stall) |-> in_stall, "input not stalled after an item was taken")

    // a fresh result only comes out of work in progress
    `FPRM_ASSERT_RST(a_result_from_work, clk, rst_n, $rose(out_valid) && $past(rst_n) |-> $past(in_stall), "result appeared with no item in flight")

    `FPRM_ASSERT_RST(a_out_hold, clk, rst_n, out_valid && out_stall |=> out_valid, "stalled result dropped")

    `FPRM_ASSERT_RST(a_out_stable, clk, rst_n, out_valid && out_stall |=> $stable(out_data), "stalled result changed")

    `FPRM_ASSERT_CLK(a_no_result_in_reset, clk, !rst_n |=> !out_valid, "result shown after reset")

endmodule

bind frame_pacer_rate_meter_unit fprm_port_checks u_fprm_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
);

// ===== tb/sv/fprm_checker.sv =====
// Checker for the frame pacer / rate meter: watches the item channels and
// the register port, predicts each result and compares. Depends on fprm_pkg.
`timescale 1ns / 1ps

module fprm_checker #(
    parameter int HISTORY_DEPTH = 60
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            in_valid,
    input  logic                            in_stall,
    input  fprm_pkg::in_item_t              in_data,
    input  logic                            out_valid,
    input  logic                            out_stall,
    input  fprm_pkg::out_item_t             out_data,
    input  logic                            cfg_we,
    input  logic [fprm_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [fprm_pkg::CFG_DATA_W-1:0] cfg_data,
    output int                              fail_count,
    output int                              pending
);
    import fprm_pkg::*;

    localparam logic [RATE_W-1:0] RATE_SAT = '1;

    logic [PERIOD_W-1:0] period_reg;
    logic [TRATE_W-1:0]  trate_reg;

    logic [TICKS_W-1:0]  start_ts;
    logic [TICKS_W-1:0]  last_frame_ts;
    logic [RATE_W-1:0]   cur_rate;
    logic [RATE_W-1:0]   avg_rate;
    logic [RATE_W-1:0]   rate_ring [HISTORY_DEPTH];
    int unsigned         ring_slot;
    int unsigned         ring_fill;
    logic [63:0]         ring_sum;

    out_item_t           frame_results_q[$];
    out_item_t           want;

    // Q16.8 rate, rounded to nearest, saturating
    function automatic logic [RATE_W-1:0] rate_of(logic [63:0] interval);
        logic [63:0] q;
        if (interval == 64'd0)
            return RATE_SAT;
        q = (({34'd0, trate_reg} << RATE_FRAC) + interval / 2) / interval;
        return (q > {40'd0, RATE_SAT}) ? RATE_SAT : q[RATE_W-1:0];
    endfunction

    // Advances the pacer state by one item and returns the result it gives
    function automatic out_item_t pace_and_measure(in_item_t it);
        out_item_t   r;
        logic [63:0] threshold;
        logic [63:0] m;
        r = '0;
        if (it.kind == KIND_BEGIN)
        begin
            start_ts      = it.now_ticks;
            last_frame_ts = it.now_ticks;
            cur_rate      = '0;
            avg_rate      = '0;
        end
        else
        begin
            r.elapsed_ticks = it.now_ticks - start_ts;
            // 48 + 32 bits cannot pass 64 bits, so no overflow guard needed
            threshold = {16'd0, last_frame_ts} + {32'd0, period_reg};
            if ({16'd0, it.now_ticks} >= threshold)
            begin
                cur_rate      = rate_of({16'd0, it.now_ticks - last_frame_ts});
                last_frame_ts = it.now_ticks;
                if (ring_fill >= HISTORY_DEPTH)
                    ring_sum -= {40'd0, rate_ring[ring_slot]};
                else
                    ring_fill++;
                rate_ring[ring_slot] = cur_rate;
                ring_sum += {40'd0, cur_rate};
                ring_slot = (ring_slot + 1 >= HISTORY_DEPTH) ? 0 : ring_slot + 1;
                m = (ring_sum + 64'(ring_fill / 2)) / 64'(ring_fill);
                avg_rate = m[RATE_W-1:0];
                r.frame_ready = 1'b1;
            end
        end
        r.frame_rate   = cur_rate;
        r.average_rate = avg_rate;
        return r;
    endfunction

    task automatic note_failure(string what);
        fail_count++;
        if (fail_count <= 10)
            $display("%0t: %s: got ready=%0d rate=%h avg=%h elapsed=%h, exp ready=%0d rate=%h avg=%h elapsed=%h",
                     $realtime, what, out_data.frame_ready, out_data.frame_rate,
                     out_data.average_rate, out_data.elapsed_ticks, want.frame_ready,
                     want.frame_rate, want.average_rate, want.elapsed_ticks);
    endtask

    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            fail_count    = 0;
            period_reg    = FRAME_PERIOD_RST;
            trate_reg     = TICK_RATE_RST;
            start_ts      = '0;
            last_frame_ts = '0;
            cur_rate      = '0;
            avg_rate      = '0;
            ring_slot     = 0;
            ring_fill     = 0;
            ring_sum      = '0;
            frame_results_q.delete();
        end
        else
        begin
            // results first, so an item taken on this edge cannot match one leaving now
            if (out_valid && !out_stall)
            begin
                if (frame_results_q.size() == 0)
                begin
                    want = '0;
                    note_failure("unexpected item");
                end
                else
                begin
                    want = frame_results_q.pop_front();
                    if (out_data.frame_ready !== want.frame_ready ||
                        out_data.frame_rate !== want.frame_rate ||
                        out_data.average_rate !== want.average_rate ||
                        out_data.elapsed_ticks !== want.elapsed_ticks)
                        note_failure("mismatch");
                end
            end
            if (in_valid && !in_stall)
                frame_results_q.push_back(pace_and_measure(in_data));
            if (cfg_we)
            begin
                case (cfg_index)
                    CFG_FRAME_PERIOD: period_reg = cfg_data[PERIOD_W-1:0];
                    CFG_TICK_RATE:    trate_reg  = cfg_data[TRATE_W-1:0];
                    default:          ;
                endcase
            end
        end
        pending = frame_results_q.size();
    end

endmodule

// ===== tb/sv/tb_top.sv =====
// Testbench top for frame_pacer_rate_meter_unit: clock, reset, register
// set-up and item stimulus under several idling patterns. Depends on
// fprm_pkg, fprm_checker and the block itself.
`timescale 1ns / 1ps

module tb_top;
    import fprm_pkg::*;

    localparam int RUN_LIMIT     = 1000000;
    localparam int DRAIN_CYCLES  = 120;
    localparam int PHASE_ITEMS   = 150;
    localparam int RANDOM_PHASES = 8;

    logic                  clk       = 1'b0;
    logic                  rst_n     = 1'b0;
    logic                  in_valid  = 1'b0;
    logic                  in_stall;
    in_item_t              in_data   = '0;
    logic                  out_valid;
    logic                  out_stall = 1'b0;
    out_item_t             out_data;
    logic                  cfg_we    = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_index = CFG_FRAME_PERIOD;
    logic [CFG_DATA_W-1:0] cfg_data  = '0;

    int                    fail_count;
    int                    pending;
    int                    cycles    = 0;
    int                    gap_pct   = 0;
    int                    stall_pct = 0;

    logic [PERIOD_W-1:0]   period_now;
    logic [TICKS_W-1:0]    ts_cursor = '0;

    always #4 clk = ~clk;

    frame_pacer_rate_meter_unit uut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_data  (out_data),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    fprm_checker #(.HISTORY_DEPTH(60)) chk (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .in_data    (in_data),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .out_data   (out_data),
        .cfg_we     (cfg_we),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .fail_count (fail_count),
        .pending    (pending)
    );

    always @(negedge clk)
        out_stall <= ($urandom_range(0, 99) < stall_pct);

    always @(posedge clk)
    begin
        cycles++;
        if (cycles > RUN_LIMIT)
        begin
            $display("CHECK FAILED");
            $finish;
        end
    end

    function automatic logic [TICKS_W-1:0] rand48();
        logic [63:0] v;
        v = {$urandom, $urandom};
        return v[TICKS_W-1:0];
    endfunction

    // valid is held across back-to-back items and only dropped for a gap
    task automatic send_item(in_item_t it);
        @(negedge clk);
        if ($urandom_range(0, 99) < gap_pct)
        begin
            in_valid <= 1'b0;
            do
                @(negedge clk);
            while ($urandom_range(0, 99) < gap_pct);
        end
        in_valid <= 1'b1;
        in_data  <= it;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
    endtask

    task automatic push_item(logic k, logic [TICKS_W-1:0] t);
        in_item_t it;
        it.kind      = k;
        it.now_ticks = t;
        ts_cursor    = t;
        send_item(it);
    endtask

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] value);
        @(negedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
    endtask

    // Registers change only with nothing in flight
    task automatic setup_phase(logic [PERIOD_W-1:0] period, logic [TRATE_W-1:0] trate,
                               int gap, int stall);
        @(negedge clk);
        in_valid <= 1'b0;
        wait (pending == 0);
        repeat (4) @(negedge clk);
        write_reg(CFG_FRAME_PERIOD, period);
        // top bits above the tick rate width should be ignored
        write_reg(CFG_TICK_RATE, {2'($urandom), trate});
        @(negedge clk);
        cfg_we     <= 1'b0;
        period_now  = period;
        gap_pct     = gap;
        stall_pct   = stall;
    endtask

    function automatic logic [TICKS_W-1:0] begin_stamp();
        int pick;
        pick = $urandom_range(0, 9);
        if (pick < 3)
            return TICKS_W'($urandom_range(0, 1000));
        else if (pick < 8)
            return rand48();
        else
            return '1 - TICKS_W'({$urandom_range(0, 15), $urandom});
    endfunction

    function automatic logic [TICKS_W-1:0] next_stamp();
        logic [63:0] step;
        step = '0;
        case ($urandom_range(0, 9))
            0, 1:    step = (period_now == 0) ? 64'd0 : 64'($urandom_range(0, period_now - 1));
            2:       step = 64'(period_now);
            8:       step = 64'($urandom_range(0, 3));
            9:       step = {24'd0, 8'($urandom), $urandom};
            default: step = 64'(period_now) + 64'($urandom_range(0, period_now / 8));
        endcase
        return ts_cursor + step[TICKS_W-1:0];
    endfunction

    // Mostly begin-then-polls runs moving forward in time, some noise
    task automatic run_random(int count);
        int sent;
        int seq_len;
        sent = 0;
        while (sent < count)
        begin
            if ($urandom_range(0, 99) < 10)
            begin
                push_item(1'($urandom_range(0, 1)), rand48());
                sent++;
            end
            else
            begin
                push_item(KIND_BEGIN, begin_stamp());
                sent++;
                seq_len = $urandom_range(4, 40);
                repeat (seq_len)
                begin
                    push_item(KIND_POLL, next_stamp());
                    sent++;
                end
            end
        end
    endtask

    initial
    begin
        repeat (8) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // defaults: poll before any begin, stamp behind last frame, wrap of elapsed
        setup_phase(32'd16667, 30'd1000000, 0, 0);
        push_item(KIND_POLL, 48'd0);
        push_item(KIND_POLL, 48'd16667);
        push_item(KIND_POLL, 48'd33340);
        push_item(KIND_POLL, 48'd33341);
        push_item(KIND_BEGIN, 48'hFFFF_FFFF_FFF0);
        push_item(KIND_POLL, 48'h5);
        push_item(KIND_POLL, 48'hFFFF_FFFF_FFFF);
        push_item(KIND_BEGIN, 48'd100);
        push_item(KIND_POLL, 48'd16767);

        // zero period: zero interval and tiny intervals saturate
        setup_phase(32'd0, 30'h3FFF_FFFF, 0, 0);
        push_item(KIND_BEGIN, 48'd1000);
        push_item(KIND_POLL, 48'd1000);
        push_item(KIND_POLL, 48'd1001);
        push_item(KIND_POLL, 48'hFFFF_FFFF_FFFF);

        // zero tick rate, widest period
        setup_phase(32'hFFFF_FFFF, 30'd0, 0, 0);
        push_item(KIND_BEGIN, 48'd0);
        push_item(KIND_POLL, 48'hFFFF_FFFE);
        push_item(KIND_POLL, 48'hFFFF_FFFF);

        // rounding, including a half-way quotient
        setup_phase(32'd1, 30'd1, 0, 0);
        push_item(KIND_BEGIN, 48'd0);
        push_item(KIND_POLL, 48'd1);
        push_item(KIND_POLL, 48'd3);
        push_item(KIND_POLL, 48'd6);
        push_item(KIND_POLL, 48'd518);

        for (int i = 0; i < RANDOM_PHASES; i++)
        begin
            logic [PERIOD_W-1:0] p;
            logic [TRATE_W-1:0]  tr;
            int                  gp;
            int                  sp;
            case (i)
                0:       begin p = 32'd16667;     tr = 30'd1000000;    end
                1:       begin p = 32'd1;         tr = 30'd1000000000; end
                2:       begin p = 32'hFFFF_FFFF; tr = 30'h3FFF_FFFF;  end
                3:       begin p = $urandom_range(1, 200000); tr = 30'($urandom); end
                4:       begin p = 32'd0;         tr = 30'($urandom);  end
                5:       begin p = $urandom;      tr = 30'd0;          end
                6:       begin p = $urandom_range(1, 5000);
                               tr = 30'($urandom_range(1, 1000000000)); end
                default: begin p = 32'd100;       tr = 30'd1;          end
            endcase
            case (i % 4)
                0:       begin gp = 0;  sp = 0;  end
                1:       begin gp = 56; sp = 0;  end
                2:       begin gp = 0;  sp = 56; end
                default: begin gp = 22; sp = 22; end
            endcase
            setup_phase(p, tr, gp, sp);
            run_random(PHASE_ITEMS);
        end

        @(negedge clk);
        in_valid <= 1'b0;
        wait (pending == 0);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (fail_count == 0 && pending == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule

// ===== frame_pacer_rate_meter_unit.f =====
+incdir+src
src/fprm_pkg.sv
src/frame_pacer_rate_meter_unit.sv
src/fprm_checker.sv
tb/sv/fprm_checker.sv
tb/sv/tb_top.sv
